// ===== hw/rtl/ps2mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse position tracker package
// Shared widths, register map and flag byte bit positions for the tracker and its
// checker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

    localparam int COORD_BITS = 12;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int BTN_W    = 3;
    localparam int MAX_W    = 12;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MAX_X        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_Y        = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOUND_ENABLE = 2'd2;

    localparam logic [MAX_W-1:0] MAX_X_RESET = MAX_W'(639);
    localparam logic [MAX_W-1:0] MAX_Y_RESET = MAX_W'(479);

    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam int XOVF_BIT  = 6;
    localparam int YOVF_BIT  = 7;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== hw/rtl/ps2_mouse_packet_position_tracker.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet position tracker
// Gathers mouse port bytes into three-byte packets and keeps a clamped
// cursor position, giving one position word per valid packet.
// ----------------------------------------------------------------------------
// Usage:
// Raw mouse bytes come in on data_byte under in_valid/in_ready. A first byte
// without its sync bit is dropped, and a packet whose flag byte shows an
// overflow is discarded; each other third byte gives one word on pos_x,
// pos_y and button_bits under out_valid/out_ready.
// A byte is held in an input register, where the packet decode and the
// position update are done, and the resulting word is then held in the
// output register. One byte is taken in every cycle while the output side
// keeps up. When the receiver stalls, the word waits in the output
// register; bytes that give no word still pass, and in_ready falls only
// when a further word is waiting behind the stalled one.
// The APB port sets max_x, max_y and bound_enable; it should be written
// only while the block is idle.
// Reset leaves the cursor at 320, 240, the packet decode at its first
// byte, and the registers at 639, 479 and bound on.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_position_tracker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ps2mpt_pkg::BYTE_W-1:0]    data_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ps2mpt_pkg::POS_W-1:0]     pos_x,
    output logic [ps2mpt_pkg::POS_W-1:0]     pos_y,
    output logic [ps2mpt_pkg::BTN_W-1:0]     button_bits,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ps2mpt_pkg::ADDR_W-1:0]    paddr,
    input  logic [ps2mpt_pkg::DATA_W-1:0]    pwdata,
    output logic [ps2mpt_pkg::DATA_W-1:0]    prdata,
    output logic                             pready
);
    import ps2mpt_pkg::*;

    localparam int SUM_W = COORD_BITS + 2;
    localparam int CMP_W = (COORD_BITS > MAX_W) ? COORD_BITS : MAX_W;
    localparam logic [SUM_W-1:0]      LIMIT = SUM_W'((1 << COORD_BITS) - 1);
    localparam logic [COORD_BITS-1:0] CURSOR_X_RESET = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET = COORD_BITS'(240);

    localparam logic [1:0] PHASE_FLAG = 2'd0;
    localparam logic [1:0] PHASE_DX   = 2'd1;
    localparam logic [1:0] PHASE_DY   = 2'd2;

    logic [MAX_W-1:0]      max_x_reg;
    logic [MAX_W-1:0]      max_y_reg;
    logic                  bound_enable_reg;

    logic                  s1_valid_reg;
    byte_t                 s1_byte_reg;

    logic [1:0]            phase_reg;
    logic [1:0]            phase_next;
    byte_t                 flag_reg;
    byte_t                 flag_next;
    byte_t                 dx_reg;
    byte_t                 dx_next;
    logic [COORD_BITS-1:0] cursor_x_reg;
    logic [COORD_BITS-1:0] cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg;
    logic [COORD_BITS-1:0] cursor_y_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [POS_W-1:0]      pos_x_reg;
    logic [POS_W-1:0]      pos_y_reg;
    logic [BTN_W-1:0]      button_reg;

    logic                  produce;
    logic                  out_free;
    logic                  s1_advance;
    logic                  cfg_write;
    logic signed [8:0]     delta_x;
    logic signed [8:0]     delta_y;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic signed [SUM_W-1:0] value,
        input logic [MAX_W-1:0]        bound,
        input logic                    bound_on
    );
        logic [COORD_BITS-1:0] sat;
        logic [COORD_BITS-1:0] result;
        if (value[SUM_W-1])
        begin
            sat = '0;
        end
        else if ($unsigned(value) > LIMIT)
        begin
            sat = LIMIT[COORD_BITS-1:0];
        end
        else
        begin
            sat = value[COORD_BITS-1:0];
        end
        result = sat;
        if (bound_on && (CMP_W'(sat) > CMP_W'(bound)))
        begin
            result = COORD_BITS'(bound);
        end
        return result;
    endfunction

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg        <= MAX_X_RESET;
            max_y_reg        <= MAX_Y_RESET;
            bound_enable_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MAX_X:        max_x_reg        <= pwdata[MAX_W-1:0];
                REG_MAX_Y:        max_y_reg        <= pwdata[MAX_W-1:0];
                REG_BOUND_ENABLE: bound_enable_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAX_X:        prdata = DATA_W'(max_x_reg);
            REG_MAX_Y:        prdata = DATA_W'(max_y_reg);
            REG_BOUND_ENABLE: prdata = DATA_W'(bound_enable_reg);
            default:          prdata = '0;
        endcase
    end

    // Packet decode and position update.
    assign delta_x = {flag_reg[XSIGN_BIT], dx_reg};
    assign delta_y = {flag_reg[YSIGN_BIT], s1_byte_reg};
    assign sum_x   = $signed({2'b00, cursor_x_reg}) + SUM_W'(delta_x);
    assign sum_y   = $signed({2'b00, cursor_y_reg}) - SUM_W'(delta_y);

    assign produce    = (phase_reg == PHASE_DY) && !flag_reg[XOVF_BIT] && !flag_reg[YOVF_BIT];
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!produce || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_comb
    begin
        phase_next     = phase_reg;
        flag_next      = flag_reg;
        dx_next        = dx_reg;
        cursor_x_next  = cursor_x_reg;
        cursor_y_next  = cursor_y_reg;
        if (s1_advance)
        begin
            unique case (phase_reg)
                PHASE_DX:
                begin
                    dx_next    = s1_byte_reg;
                    phase_next = PHASE_DY;
                end
                PHASE_DY:
                begin
                    phase_next = PHASE_FLAG;
                    if (produce)
                    begin
                        cursor_x_next = clamp_coord(sum_x, max_x_reg, bound_enable_reg);
                        cursor_y_next = clamp_coord(sum_y, max_y_reg, bound_enable_reg);
                    end
                end
                default:
                begin
                    phase_next = PHASE_FLAG;
                    if (s1_byte_reg[SYNC_BIT])
                    begin
                        flag_next  = s1_byte_reg;
                        phase_next = PHASE_DX;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_advance && produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PHASE_FLAG;
            flag_reg      <= '0;
            dx_reg        <= '0;
            cursor_x_reg  <= CURSOR_X_RESET;
            cursor_y_reg  <= CURSOR_Y_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            phase_reg     <= phase_next;
            flag_reg      <= flag_next;
            dx_reg        <= dx_next;
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= data_byte;
        end
        if (s1_advance && produce)
        begin
            pos_x_reg  <= POS_W'(cursor_x_next);
            pos_y_reg  <= POS_W'(cursor_y_next);
            button_reg <= flag_reg[BTN_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign button_bits = button_reg;

endmodule

// ===== hw/rtl/ps2mpt_checker.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse position tracker checker
// Port-level assertions on the tracker, attached by a bind statement.
// ----------------------------------------------------------------------------
module ps2mpt_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [ps2mpt_pkg::POS_W-1:0]     pos_x,
    input logic [ps2mpt_pkg::POS_W-1:0]     pos_y,
    input logic [ps2mpt_pkg::BTN_W-1:0]     button_bits,
    input logic                             psel,
    input logic                             pwrite,
    input logic [ps2mpt_pkg::ADDR_W-1:0]    paddr,
    input logic [ps2mpt_pkg::DATA_W-1:0]    prdata
);
    import ps2mpt_pkg::*;

    // A stalled word keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(button_bits))
    else $error("output word changed while stalled");

    // With the receiver ready, nothing can hold the input back.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("input stalled although the output side is ready");

    // The bound registers read back no more than their width.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && ((paddr[3:2] == REG_MAX_X) || (paddr[3:2] == REG_MAX_Y))
            |-> prdata[DATA_W-1:MAX_W] == '0)
    else $error("maximum register reads back stray upper bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite && (paddr[3:2] == REG_BOUND_ENABLE) |-> prdata[DATA_W-1:1] == '0)
    else $error("bound enable register reads back stray upper bits");

    // An idle input side with an empty pipeline gives no new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_valid ##1 !out_valid && !in_valid |=> !out_valid)
    else $error("output word appeared without input");

endmodule

bind ps2_mouse_packet_position_tracker ps2mpt_checker u_ps2mpt_checker (.*);
